>>> design/i2cseq_pkg.sv
// shared types, status codes and fault codes of the i2c register sequencer
package i2cseq_pkg;

  // byte engine status codes
  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_RESTART      = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK    = 8'h18;
  localparam logic [7:0] ST_SLA_W_NACK   = 8'h20;
  localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_TX_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST     = 8'h38;
  localparam logic [7:0] ST_SLA_R_ACK    = 8'h40;
  localparam logic [7:0] ST_SLA_R_NACK   = 8'h48;
  localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;

  // longest read in bytes
  localparam logic [5:0] MAX_READ = 6'd32;

  // item kinds carried on tuser
  localparam logic MODE_REQUEST = 1'b0;
  localparam logic MODE_EVENT   = 1'b1;

  typedef enum logic [2:0] {
    FLT_NONE       = 3'd0,
    FLT_ADDR_NACK  = 3'd1,
    FLT_DATA_NACK  = 3'd2,
    FLT_ARB_LOST   = 3'd3,
    FLT_BAD_STATUS = 3'd4,
    FLT_BUSY       = 3'd5
  } fault_t;

  // input payload, last member in the lowest bits
  typedef struct packed {
    logic [7:0] bus_byte;
    logic [7:0] bus_status;
    logic [7:0] write_value;
    logic [5:0] read_length;
    logic [7:0] register_index;
    logic [7:0] device_byte;
    logic       is_write;
  } in_data_t;

  typedef struct packed {
    logic     mode;
    in_data_t data;
  } in_item_t;

  // result payload, last member in the lowest bits
  typedef struct packed {
    logic [7:0] reported_status;
    fault_t     fault;
    logic       busy_res;
    logic       done_res;
    logic [4:0] rx_index;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       ack_next;
    logic       send_stop;
    logic       send_start;
    logic [7:0] load_byte;
    logic       load_valid;
  } out_item_t;

  localparam int IN_BITS    = $bits(in_data_t);
  localparam int OUT_BITS   = $bits(out_item_t);
  localparam int IN_TDATAW  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATAW = ((OUT_BITS + 7) / 8) * 8;

endpackage

>>> design/i2cseq_in_stage.sv
// input register stage of the i2c register sequencer
module i2cseq_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  i2cseq_pkg::in_item_t in_item,
  input  logic                advance,
  output logic                stage_valid,
  output i2cseq_pkg::in_item_t stage_item
);
  import i2cseq_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  // valid flag: set on a new item, cleared when the item moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_fire) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item;
    end
  end

  assign stage_valid = valid_r;
  assign stage_item  = item_r;

endmodule

>>> design/i2cseq_engine.sv
// transaction state and per-item decision logic of the i2c register sequencer
module i2cseq_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  i2cseq_pkg::in_item_t item,
  output i2cseq_pkg::out_item_t result
);
  import i2cseq_pkg::*;

  logic       active_r,        active_nxt;
  logic       write_dir_r,     write_dir_nxt;
  logic [7:0] held_device_r,   held_device_nxt;
  logic [7:0] held_register_r, held_register_nxt;
  logic [7:0] held_value_r,    held_value_nxt;
  logic       value_sent_r,    value_sent_nxt;
  logic [5:0] bytes_taken_r,   bytes_taken_nxt;
  logic [5:0] bytes_wanted_r,  bytes_wanted_nxt;
  logic [7:0] last_code_r,     last_code_nxt;

  logic [5:0] want;
  logic       room;
  logic [5:0] taken_after;
  logic [6:0] taken_plus;
  out_item_t  res;

  // clamp the requested read length to one..MAX_READ
  always_comb begin
    want = item.data.read_length;
    if (want == 6'd0) begin
      want = 6'd1;
    end else if (want > MAX_READ) begin
      want = MAX_READ;
    end
  end

  // received byte bookkeeping
  assign room        = bytes_taken_r < bytes_wanted_r;
  assign taken_after = room ? bytes_taken_r + 6'd1 : bytes_taken_r;
  assign taken_plus  = {1'b0, taken_after} + 7'd1;

  // decision for one item
  always_comb begin
    res               = '0;
    active_nxt        = active_r;
    write_dir_nxt     = write_dir_r;
    held_device_nxt   = held_device_r;
    held_register_nxt = held_register_r;
    held_value_nxt    = held_value_r;
    value_sent_nxt    = value_sent_r;
    bytes_taken_nxt   = bytes_taken_r;
    bytes_wanted_nxt  = bytes_wanted_r;
    last_code_nxt     = last_code_r;

    if (item.mode == MODE_REQUEST) begin
      if (active_r) begin
        res.fault = FLT_BUSY;
      end else begin
        active_nxt        = 1'b1;
        write_dir_nxt     = item.data.is_write;
        held_device_nxt   = item.data.device_byte;
        held_register_nxt = item.data.register_index;
        held_value_nxt    = item.data.write_value;
        value_sent_nxt    = 1'b0;
        bytes_taken_nxt   = 6'd0;
        bytes_wanted_nxt  = want;
        res.send_start    = 1'b1;
      end
    end else if (active_r) begin
      if (write_dir_r) begin
        // register write sequence
        case (item.data.bus_status)
          ST_START: begin
            res.load_valid = 1'b1;
            res.load_byte  = held_device_r;
            last_code_nxt  = ST_START;
          end
          ST_SLA_W_ACK: begin
            res.load_valid = 1'b1;
            res.load_byte  = held_register_r;
            last_code_nxt  = ST_SLA_W_ACK;
          end
          ST_DATA_TX_ACK: begin
            if (value_sent_r) begin
              res.send_stop = 1'b1;
              res.done_res  = 1'b1;
              active_nxt    = 1'b0;
            end else begin
              res.load_valid = 1'b1;
              res.load_byte  = held_value_r;
              value_sent_nxt = 1'b1;
              last_code_nxt  = ST_DATA_TX_ACK;
            end
          end
          ST_SLA_W_NACK: begin
            res.send_stop = 1'b1;
            res.done_res  = 1'b1;
            res.fault     = FLT_ADDR_NACK;
            last_code_nxt = item.data.bus_status;
            active_nxt    = 1'b0;
          end
          ST_DATA_TX_NACK: begin
            res.send_stop = 1'b1;
            res.done_res  = 1'b1;
            res.fault     = FLT_DATA_NACK;
            last_code_nxt = item.data.bus_status;
            active_nxt    = 1'b0;
          end
          ST_ARB_LOST: begin
            res.done_res  = 1'b1;
            res.fault     = FLT_ARB_LOST;
            last_code_nxt = item.data.bus_status;
            active_nxt    = 1'b0;
          end
          default: begin
            res.send_stop = 1'b1;
            res.done_res  = 1'b1;
            res.fault     = FLT_BAD_STATUS;
            last_code_nxt = item.data.bus_status;
            active_nxt    = 1'b0;
          end
        endcase
      end else begin
        // register read sequence
        case (item.data.bus_status)
          ST_START: begin
            res.load_valid = 1'b1;
            res.load_byte  = held_device_r;
          end
          ST_SLA_W_ACK: begin
            res.load_valid = 1'b1;
            res.load_byte  = held_register_r;
          end
          ST_DATA_TX_ACK: begin
            res.send_start  = 1'b1;
            bytes_taken_nxt = 6'd0;
          end
          ST_RESTART: begin
            res.load_valid = 1'b1;
            res.load_byte  = held_device_r | 8'h01;
          end
          ST_SLA_R_NACK: begin
            res.send_start = 1'b1;
            res.send_stop  = 1'b1;
          end
          ST_SLA_R_ACK: begin
            bytes_taken_nxt = 6'd0;
            res.ack_next    = 6'd1 < bytes_wanted_r;
          end
          ST_DATA_RX_ACK: begin
            res.rx_valid    = room;
            res.rx_byte     = room ? item.data.bus_byte : 8'h00;
            res.rx_index    = room ? bytes_taken_r[4:0] : 5'd0;
            bytes_taken_nxt = taken_after;
            res.ack_next    = taken_plus < {1'b0, bytes_wanted_r};
          end
          ST_DATA_RX_NACK: begin
            res.rx_valid    = room;
            res.rx_byte     = room ? item.data.bus_byte : 8'h00;
            res.rx_index    = room ? bytes_taken_r[4:0] : 5'd0;
            bytes_taken_nxt = taken_after;
            res.send_stop   = 1'b1;
            res.done_res    = 1'b1;
            active_nxt      = 1'b0;
          end
          default: begin
            res.send_stop = 1'b1;
            res.done_res  = 1'b1;
            res.fault     = FLT_BAD_STATUS;
            last_code_nxt = item.data.bus_status;
            active_nxt    = 1'b0;
          end
        endcase
      end
    end

    res.busy_res        = active_nxt;
    res.reported_status = last_code_nxt;
  end

  // transaction state, updated as each item leaves for the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r        <= 1'b0;
      write_dir_r     <= 1'b0;
      held_device_r   <= 8'h00;
      held_register_r <= 8'h00;
      held_value_r    <= 8'h00;
      value_sent_r    <= 1'b0;
      bytes_taken_r   <= 6'd0;
      bytes_wanted_r  <= 6'd0;
      last_code_r     <= 8'h00;
    end else if (advance) begin
      active_r        <= active_nxt;
      write_dir_r     <= write_dir_nxt;
      held_device_r   <= held_device_nxt;
      held_register_r <= held_register_nxt;
      held_value_r    <= held_value_nxt;
      value_sent_r    <= value_sent_nxt;
      bytes_taken_r   <= bytes_taken_nxt;
      bytes_wanted_r  <= bytes_wanted_nxt;
      last_code_r     <= last_code_nxt;
    end
  end

  assign result = res;

endmodule

>>> design/i2cseq_out_stage.sv
// result register stage of the i2c register sequencer
module i2cseq_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  i2cseq_pkg::out_item_t result,
  input  logic                  out_ready,
  output logic                  out_valid,
  output i2cseq_pkg::out_item_t out_item
);
  import i2cseq_pkg::*;

  logic      valid_r;
  out_item_t item_r;

  // valid flag: set on a new result, cleared once it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (advance) begin
      item_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

>>> design/i2c_master_register_sequencer.sv
// top level of the i2c register sequencer
//
// Sits between a host and a byte-level i2c master engine. The input channel
// carries two kinds of item, told apart by in_tuser: a request (0) starts a
// register write or a register read, an event (1) passes on a status code
// and received byte from the engine. Every accepted item gives exactly one
// result item on the output channel, holding the next engine command, any
// received byte with its index, completion, busy and fault indications.
//
// An accepted item is held in the input register; its result item is
// computed from it and the transaction state and is captured in the result
// register when the item moves on.
// Throughput: one item per cycle while results are taken; the transaction
// state is updated in the same cycle as an item moves from the input
// register to the result register, so the following item already sees it.
// When the receiver stalls, the result register holds its item and the
// input register still takes one more item if it is empty; after that
// in_tready drops until out_tready returns.
// Reset (rst_n low at a clock edge) empties both registers and returns the
// transaction state to idle with all held values and the status at zero.
module i2c_master_register_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // in_tdata: is_write, device_byte, register_index, read_length,
  // write_value, bus_status, bus_byte, zero pad
  input  logic [i2cseq_pkg::IN_TDATAW-1:0]    in_tdata,
  // in_tuser: mode
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_tdata: load_valid, load_byte, send_start, send_stop, ack_next,
  // rx_valid, rx_byte, rx_index, done_res, busy_res, fault,
  // reported_status, zero pad
  output logic [i2cseq_pkg::OUT_TDATAW-1:0]   out_tdata
);
  import i2cseq_pkg::*;

  logic      in_fire;
  logic      advance;
  logic      stage_valid;
  in_item_t  in_item;
  in_item_t  stage_item;
  out_item_t result;
  out_item_t out_item;

  // item moves on when the result register is empty or being emptied
  assign advance   = stage_valid && (!out_tvalid || out_tready);
  assign in_tready = !stage_valid || advance;
  assign in_fire   = in_tvalid && in_tready;

  // unpack the input item
  assign in_item.mode = in_tuser;
  assign in_item.data = in_data_t'(in_tdata[IN_BITS-1:0]);

  i2cseq_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_item     (in_item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  i2cseq_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (stage_item),
    .result  (result)
  );

  i2cseq_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .result    (result),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_item  (out_item)
  );

  // pack the result item, padded with zeros
  assign out_tdata = {{(OUT_TDATAW - OUT_BITS){1'b0}}, out_item};

endmodule

>>> design/i2cseq_checker.sv
// port-level checks of the i2c register sequencer, bound to the top level
module i2cseq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [i2cseq_pkg::OUT_TDATAW-1:0] out_tdata
);
  import i2cseq_pkg::*;

  out_item_t res;

  assign res = out_item_t'(out_tdata[OUT_BITS-1:0]);

  // a stalled result item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // reset empties the result register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result item present after reset");

  // a finished transaction leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.done_res |-> !res.busy_res)
    else $error("done reported while still busy");

  // a transaction fault always ends the transaction
  a_fault_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.fault != FLT_NONE && res.fault != FLT_BUSY
      |-> res.done_res && !res.busy_res)
    else $error("fault without completion");

  // a refused request issues no command and keeps the block busy
  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.fault == FLT_BUSY
      |-> res.busy_res && !res.send_start && !res.load_valid && !res.done_res)
    else $error("refused request changed the bus");

endmodule

bind i2c_master_register_sequencer i2cseq_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
